// ===== sv/rmpu_pkg.sv =====
// shared types and constants for the rational multiply and power unit
package rmpu_pkg;
    localparam int WORD_BITS = 32;
    localparam int EXP_BITS  = 16;
    localparam int MAG_BITS  = EXP_BITS + 1;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

    typedef logic [WORD_BITS-1:0] word_t;

    localparam logic OP_MULTIPLY = 1'b0;
    localparam logic OP_POWER    = 1'b1;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_MUL    = 11'b00000000010,
        ST_GCHK   = 11'b00000000100,
        ST_MOD    = 11'b00000001000,
        ST_MODSTP = 11'b00000010000,
        ST_DIVN   = 11'b00000100000,
        ST_DIVD   = 11'b00001000000,
        ST_DIVSTP = 11'b00010000000,
        ST_PWR    = 11'b00100000000,
        ST_PWRSTP = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } state_t;
endpackage

// ===== sv/rational_multiply_power_unit.sv =====
// rational multiply and power unit with a shared multiplier and restoring divider
//
// channel   dir  fields
// s_axis    in   tdata: operation, a_positive, a_numer, a_denom, b_positive,
//                       b_numer, b_denom, reduce, exponent
// m_axis    out  tdata: result_positive, result_numer, result_denom
//
// one item at a time; s_axis_tready is high only when idle
// multiply: two products; reduce adds a gcd check, a divider pass per euclid step,
// then the last euclid check and the two quotient divisions
// power: same gcd path, then a setup state, a squaring per exponent bit and a
// multiply per set bit; a 32-bit euclid takes about 45 steps at worst
// reset clears all registers and output valid; a stalled result holds
module rational_multiply_power_unit
    import rmpu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[0], a_positive[1], a_numer[33:2], a_denom[65:34], b_positive[66],
    // b_numer[98:67], b_denom[130:99], reduce[131], exponent[147:132], zero pad
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_positive[0], result_numer[32:1], result_denom[64:33], zero pad
    output logic [71:0]  m_axis_tdata
);
    state_t state_reg;
    logic out_valid_reg;
    logic op_reg, pos_reg, pwr_reg;
    word_t n_reg, d_reg, bn_reg, bd_reg;
    word_t x_reg, y_reg;
    word_t acc_n_reg, acc_d_reg;
    logic [MAG_BITS-1:0] mag_reg;
    // divider
    word_t dvd_reg, dvs_reg, quo_reg;
    word_t rem_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    // shared multiplier operands and product
    word_t mul_a, mul_b, mul_p;
    logic [2*WORD_BITS-1:0] mul_full;
    logic [WORD_BITS:0] rem_sh, rem_sub;
    logic [1:0] pstep_reg;
    logic [EXP_BITS-1:0] e_in;
    logic [MAG_BITS-1:0] mag_in;
    logic in_acc;

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, acc_d_reg, acc_n_reg, pos_reg};
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign e_in   = s_axis_tdata[147:132];
    assign mag_in = e_in[EXP_BITS-1] ? (MAG_BITS'(1) << EXP_BITS) - {1'b0, e_in}
                                     : {1'b0, e_in};

    // shared multiplier
    assign mul_full = mul_a * mul_b;
    assign mul_p    = mul_full[WORD_BITS-1:0];
    always_comb
    begin
        mul_a = n_reg;
        mul_b = bn_reg;
        case (pstep_reg)
            2'd0: begin mul_a = n_reg; mul_b = bn_reg; end
            2'd1: begin mul_a = d_reg; mul_b = bd_reg; end
            2'd2: begin mul_a = acc_n_reg; mul_b = n_reg; end
            default: begin mul_a = acc_d_reg; mul_b = d_reg; end
        endcase
    end

    // divider step
    assign rem_sh  = {rem_reg, dvd_reg[WORD_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pstep_reg     <= 2'd0;
            op_reg        <= 1'b0;
            pos_reg       <= 1'b0;
            pwr_reg       <= 1'b0;
            n_reg         <= '0;
            d_reg         <= '0;
            bn_reg        <= '0;
            bd_reg        <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            acc_n_reg     <= '0;
            acc_d_reg     <= '0;
            mag_reg       <= '0;
            dvd_reg       <= '0;
            dvs_reg       <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        op_reg  <= s_axis_tdata[0];
                        bn_reg  <= s_axis_tdata[98:67];
                        bd_reg  <= s_axis_tdata[130:99];
                        mag_reg <= mag_in;
                        pstep_reg <= 2'd0;
                        if (s_axis_tdata[0] == OP_MULTIPLY)
                        begin
                            pos_reg <= s_axis_tdata[1] == s_axis_tdata[66];
                            n_reg   <= s_axis_tdata[33:2];
                            d_reg   <= s_axis_tdata[65:34];
                            pwr_reg <= s_axis_tdata[131];
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            pos_reg <= s_axis_tdata[1] || !mag_in[0];
                            pwr_reg <= 1'b1;
                            if (e_in[EXP_BITS-1])
                            begin
                                n_reg <= s_axis_tdata[65:34];
                                d_reg <= s_axis_tdata[33:2];
                            end
                            else
                            begin
                                n_reg <= s_axis_tdata[33:2];
                                d_reg <= s_axis_tdata[65:34];
                            end
                            if (e_in == '0)
                            begin
                                acc_n_reg <= word_t'(1);
                                acc_d_reg <= word_t'(1);
                                state_reg <= ST_OUT;
                                out_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= ST_GCHK;
                            end
                        end
                    end
                end
                // two products through the shared multiplier
                ST_MUL:
                begin
                    if (pstep_reg == 2'd0)
                    begin
                        acc_n_reg <= mul_p;
                        pstep_reg <= 2'd1;
                    end
                    else
                    begin
                        acc_d_reg <= mul_p;
                        n_reg     <= acc_n_reg;
                        d_reg     <= mul_p;
                        if (!pwr_reg)
                        begin
                            state_reg <= ST_OUT;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_GCHK;
                        end
                    end
                end
                // gcd is one when either value is below two
                ST_GCHK:
                begin
                    x_reg <= n_reg;
                    y_reg <= d_reg;
                    if (n_reg < word_t'(2) || d_reg < word_t'(2))
                    begin
                        if (op_reg == OP_POWER)
                        begin
                            acc_n_reg <= word_t'(1);
                            acc_d_reg <= word_t'(1);
                            state_reg <= ST_PWR;
                        end
                        else
                        begin
                            acc_n_reg <= n_reg;
                            acc_d_reg <= d_reg;
                            state_reg <= ST_OUT;
                            out_valid_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_MOD;
                    end
                end
                // euclid: start x mod y, or finish with gcd in x
                ST_MOD:
                begin
                    if (y_reg == '0)
                    begin
                        dvd_reg <= n_reg;
                        dvs_reg <= x_reg;
                        state_reg <= ST_DIVN;
                    end
                    else
                    begin
                        dvd_reg <= x_reg;
                        dvs_reg <= y_reg;
                        rem_reg <= '0;
                        cnt_reg <= CNT_BITS'(WORD_BITS);
                        state_reg <= ST_MODSTP;
                    end
                end
                ST_MODSTP, ST_DIVSTP:
                begin
                    dvd_reg <= {dvd_reg[WORD_BITS-2:0], 1'b0};
                    if (!rem_sub[WORD_BITS])
                    begin
                        rem_reg <= rem_sub[WORD_BITS-1:0];
                        quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[WORD_BITS-1:0];
                        quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CNT_BITS'(1);
                    if (cnt_reg == CNT_BITS'(1))
                    begin
                        if (state_reg == ST_MODSTP)
                        begin
                            x_reg <= y_reg;
                            y_reg <= !rem_sub[WORD_BITS] ? rem_sub[WORD_BITS-1:0]
                                                         : rem_sh[WORD_BITS-1:0];
                            state_reg <= ST_MOD;
                        end
                        else if (pstep_reg == 2'd0)
                        begin
                            n_reg <= {quo_reg[WORD_BITS-2:0], !rem_sub[WORD_BITS]};
                            pstep_reg <= 2'd1;
                            state_reg <= ST_DIVD;
                        end
                        else
                        begin
                            d_reg <= {quo_reg[WORD_BITS-2:0], !rem_sub[WORD_BITS]};
                            if (op_reg == OP_POWER)
                            begin
                                acc_n_reg <= word_t'(1);
                                acc_d_reg <= word_t'(1);
                                state_reg <= ST_PWR;
                            end
                            else
                            begin
                                acc_n_reg <= n_reg;
                                acc_d_reg <= {quo_reg[WORD_BITS-2:0], !rem_sub[WORD_BITS]};
                                state_reg <= ST_OUT;
                                out_valid_reg <= 1'b1;
                            end
                        end
                    end
                end
                // start a quotient division
                ST_DIVN:
                begin
                    rem_reg <= '0;
                    cnt_reg <= CNT_BITS'(WORD_BITS);
                    pstep_reg <= 2'd0;
                    state_reg <= ST_DIVSTP;
                end
                ST_DIVD:
                begin
                    dvd_reg <= d_reg;
                    rem_reg <= '0;
                    cnt_reg <= CNT_BITS'(WORD_BITS);
                    state_reg <= ST_DIVSTP;
                end
                // square and multiply, lsb first; steps 2,3 multiply, 0,1 square
                ST_PWR:
                begin
                    pstep_reg <= mag_reg[0] ? 2'd2 : 2'd0;
                    bn_reg <= n_reg;
                    bd_reg <= d_reg;
                    state_reg <= ST_PWRSTP;
                end
                ST_PWRSTP:
                begin
                    case (pstep_reg)
                        2'd2: begin acc_n_reg <= mul_p; pstep_reg <= 2'd3; end
                        2'd3: begin acc_d_reg <= mul_p; pstep_reg <= 2'd0; end
                        2'd0:
                        begin
                            n_reg <= mul_p;
                            bn_reg <= mul_p;
                            pstep_reg <= 2'd1;
                        end
                        default:
                        begin
                            d_reg <= mul_p;
                            bd_reg <= mul_p;
                            mag_reg <= mag_reg >> 1;
                            if ((mag_reg >> 1) == '0)
                            begin
                                state_reg <= ST_OUT;
                                out_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                pstep_reg <= mag_reg[1] ? 2'd2 : 2'd0;
                            end
                        end
                    endcase
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the rational multiply and power unit
module tb_top;
    import rmpu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RAND_ITEMS  = 1250;
    localparam int  CYCLE_LIMIT = 12000000;

    typedef struct packed {
        logic [15:0] exponent;
        logic        reduce;
        logic [31:0] b_denom;
        logic [31:0] b_numer;
        logic        b_positive;
        logic [31:0] a_denom;
        logic [31:0] a_numer;
        logic        a_positive;
        logic        operation;
    } fraction_op_t;

    typedef struct packed {
        logic [31:0] result_denom;
        logic [31:0] result_numer;
        logic        result_positive;
    } fraction_res_t;

    typedef struct {
        fraction_op_t  op;
        logic          known;
        fraction_res_t res;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    fraction_res_t expected_fractions[$];
    stim_row_t     stim_rows[$];
    int            error_count;
    int            cycle_count;
    bit            quiet_phase;

    rational_multiply_power_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // gcd with the rule that anything below 2 gives 1
    function automatic logic [31:0] gcd_word(logic [31:0] x, logic [31:0] y);
        logic [31:0] t;
        if (x < 2 || y < 2)
            return 32'd1;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // square and multiply with 32-bit wrap
    function automatic logic [31:0] pow_wrap(logic [31:0] base, logic [16:0] mag);
        logic [31:0] acc;
        acc = 32'd1;
        while (mag != 0)
        begin
            if (mag[0])
                acc = acc * base;
            base = base * base;
            mag  = mag >> 1;
        end
        return acc;
    endfunction

    function automatic fraction_res_t predict_fraction(fraction_op_t op);
        fraction_res_t r;
        logic [31:0]   n, d, g;
        logic [16:0]   mag;
        if (op.operation == OP_MULTIPLY)
        begin
            r.result_positive = (op.a_positive == op.b_positive);
            n = op.a_numer * op.b_numer;
            d = op.a_denom * op.b_denom;
            if (op.reduce)
            begin
                g = gcd_word(n, d);
                n = n / g;
                d = d / g;
            end
        end
        else if (op.exponent == 16'd0)
        begin
            r.result_positive = 1'b1;
            n = 32'd1;
            d = 32'd1;
        end
        else
        begin
            if (op.exponent[15])
            begin
                mag = 17'h10000 - {1'b0, op.exponent};
                n   = op.a_denom;
                d   = op.a_numer;
            end
            else
            begin
                mag = {1'b0, op.exponent};
                n   = op.a_numer;
                d   = op.a_denom;
            end
            g = gcd_word(n, d);
            n = pow_wrap(n / g, mag);
            d = pow_wrap(d / g, mag);
            r.result_positive = op.a_positive || !mag[0];
        end
        r.result_numer = n;
        r.result_denom = d;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic fraction_op_t mk_op(logic opr, logic ap, logic [31:0] an,
        logic [31:0] ad, logic bp, logic [31:0] bn, logic [31:0] bd, logic red,
        logic [15:0] ex);
        fraction_op_t o;
        o = '{exponent: ex, reduce: red, b_denom: bd, b_numer: bn, b_positive: bp,
              a_denom: ad, a_numer: an, a_positive: ap, operation: opr};
        return o;
    endfunction

    task automatic add_row(fraction_op_t op, logic known, fraction_res_t res);
        stim_row_t row;
        row.op    = op;
        row.known = known;
        row.res   = res;
        stim_rows.push_back(row);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3);
            1: return $urandom_range(0, 255);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            3: return $urandom_range(2, 12) * $urandom_range(1, 60);
            default: return $urandom;
        endcase
    endfunction

    function automatic fraction_op_t rand_op();
        fraction_op_t o;
        logic [15:0]  ex;
        case ($urandom_range(0, 9))
            0: ex = 16'($urandom);
            1: ex = 16'h8000 + 16'($urandom_range(0, 3));
            2: ex = 16'h7FFF - 16'($urandom_range(0, 3));
            default: ex = 16'($urandom_range(0, 40)) - 16'd20;
        endcase
        o = mk_op(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_word(),
                  rand_word(), 1'($urandom_range(0, 1)), rand_word(), rand_word(),
                  1'($urandom_range(0, 1)), ex);
        return o;
    endfunction

    // valid stays high between back-to-back transfers; outside the quiet phase random idle gaps drop it
    task automatic send_fraction(fraction_op_t op);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_axis_tdata  <= {4'd0, op};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_fractions.push_back(predict_fraction(op));
        @(negedge clk);
    endtask

    // result sink with random stall bursts
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        fraction_res_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[64:0];
            if (expected_fractions.size() == 0)
            begin
                report_mismatch("result transfer with nothing expected");
            end
            else
            begin
                want = expected_fractions.pop_front();
                if (got.result_positive !== want.result_positive)
                    report_mismatch($sformatf("sign: got %h expected %h",
                                    got.result_positive, want.result_positive));
                if (got.result_numer !== want.result_numer)
                    report_mismatch($sformatf("numer: got %h expected %h",
                                    got.result_numer, want.result_numer));
                if (got.result_denom !== want.result_denom)
                    report_mismatch($sformatf("denom: got %h expected %h",
                                    got.result_denom, want.result_denom));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[rational_multiply_power_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        fraction_res_t one_res, r;
        fraction_op_t  op;
        int            wait_cycles;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        error_count   = 0;
        cycle_count   = 0;
        quiet_phase   = 1'b0;
        one_res = '{result_denom: 32'd1, result_numer: 32'd1, result_positive: 1'b1};

        // directed table: known rows carry a typed result
        add_row(mk_op(OP_POWER, 1'b0, 32'd7, 32'd3, 1'b0, 0, 0, 1'b0, 16'd0), 1'b1, one_res);
        r = '{result_denom: 32'd1, result_numer: 32'd0, result_positive: 1'b1};
        add_row(mk_op(OP_MULTIPLY, 1'b1, 32'd0, 32'd1, 1'b1, 32'd5, 32'd1, 1'b1, 16'd0),
                1'b1, r);
        r = '{result_denom: 32'd1, result_numer: 32'd1, result_positive: 1'b1};
        add_row(mk_op(OP_MULTIPLY, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'hFFFF), 1'b1, r);
        r = '{result_denom: 32'd2, result_numer: 32'd3, result_positive: 1'b0};
        add_row(mk_op(OP_MULTIPLY, 1'b1, 32'd6, 32'd4, 1'b0, 32'd1, 32'd1, 1'b1, 16'd0),
                1'b1, r);
        r = '{result_denom: 32'd4, result_numer: 32'd6, result_positive: 1'b0};
        add_row(mk_op(OP_MULTIPLY, 1'b1, 32'd6, 32'd4, 1'b0, 32'd1, 32'd1, 1'b0, 16'd0),
                1'b1, r);
        r = '{result_denom: 32'd0, result_numer: 32'd1, result_positive: 1'b1};
        add_row(mk_op(OP_MULTIPLY, 1'b0, 32'd5, 32'd0, 1'b1, 32'd1, 32'd9, 1'b1, 16'd0),
                1'b0, r);
        add_row(mk_op(OP_POWER, 1'b0, 32'd2, 32'd3, 1'b1, 0, 0, 1'b1, 16'd3), 1'b0, r);
        add_row(mk_op(OP_POWER, 1'b0, 32'd2, 32'd3, 1'b1, 0, 0, 1'b0, 16'd2), 1'b0, r);
        add_row(mk_op(OP_POWER, 1'b0, 32'd4, 32'd6, 1'b0, 0, 0, 1'b0, 16'hFFFD), 1'b0, r);
        add_row(mk_op(OP_POWER, 1'b1, 32'd3, 32'd5, 1'b0, 0, 0, 1'b0, 16'h8000), 1'b0, r);
        add_row(mk_op(OP_POWER, 1'b0, 32'd3, 32'd5, 1'b0, 0, 0, 1'b0, 16'h7FFF), 1'b0, r);
        add_row(mk_op(OP_POWER, 1'b1, 32'd0, 32'd0, 1'b0, 0, 0, 1'b0, 16'd5), 1'b0, r);
        add_row(mk_op(OP_POWER, 1'b0, 32'd1, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      1'b1, 16'hFFFF), 1'b0, r);
        add_row(mk_op(OP_POWER, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 0, 0, 1'b0,
                      16'd1), 1'b0, r);
        add_row(mk_op(OP_MULTIPLY, 1'b1, 32'h0001_0000, 32'd12, 1'b1, 32'h0001_0000,
                      32'd18, 1'b1, 16'h1234), 1'b0, r);
        add_row(mk_op(OP_MULTIPLY, 1'b1, 32'd1, 32'd7, 1'b1, 32'd1, 32'd1, 1'b1, 16'd0),
                1'b0, r);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].known && predict_fraction(stim_rows[i].op) !== stim_rows[i].res)
                report_mismatch($sformatf("table row %0d disagrees with prediction", i));
            send_fraction(stim_rows[i].op);
        end

        // random items, last part without idling
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == RAND_ITEMS - 100)
                quiet_phase = 1'b1;
            op = rand_op();
            send_fraction(op);
        end
        s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (expected_fractions.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (400) @(posedge clk);
        if (error_count == 0 && expected_fractions.size() == 0)
            $display("[rational_multiply_power_unit] OK");
        else
            $display("[rational_multiply_power_unit] ERROR");
        $finish;
    end
endmodule
